// ===== sv/kfd_pkg.sv =====
`default_nettype none
package kfd_pkg;

   // KISS special characters
   localparam logic [7:0] KISS_FEND  = 8'hC0;
   localparam logic [7:0] KISS_FESC  = 8'hDB;
   localparam logic [7:0] KISS_TFEND = 8'hDC;
   localparam logic [7:0] KISS_TFESC = 8'hDD;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam int LEN_W = 9;

   typedef enum logic {
      KIND_DATA = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_GOOD      = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_NOT_DATA  = 2'd2,
      ST_BAD_PORT  = 2'd3
   } status_type;

   // One classified event from the front end: a frame boundary or a byte.
   typedef struct packed {
      logic       is_end;
      logic [7:0] value;
   } event_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      kind_type       kind;
      logic [7:0]     data_byte;
      logic [3:0]     port;
      logic [LEN_W-1:0] payload_length;
      status_type     status;
   } result_type;

endpackage
`default_nettype wire

// ===== sv/kiss_frame_deframer.sv =====
// KISS receive deframer.
// The req_ stream carries raw bytes from the serial line, one request per byte.
// The rsp_ stream returns a result per payload byte of an accepted data frame
// (rsp_tuser low) and one end-of-frame result per nonempty frame (rsp_tuser
// high) that reports the port, the payload length and a status code.
// The max_ports register is written through csr_wr_en and csr_wr_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce. Reset sets it to zero, which rejects every port. A byte
// is taken every cycle while the event queue is not full. Its result, if any,
// reaches the rsp_ side through the event queue and the output register: the
// escape decoder writes the event queue at the accepting edge, and the frame
// tracker loads its output register when it takes the event from the queue.
// Sustained throughput is one byte per cycle while rsp_tready stays high. When
// the receiver stalls, a result waits in the output register and the
// four-entry event queue fills; req_tready falls once that queue is full. Reset
// empties the queue, drops any partial frame and escape, and clears the output valid flag.
`default_nettype none
module kiss_frame_deframer #(
   parameter int MAX_FRAME = 400
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration: max_ports
   input  wire logic        csr_wr_en,
   input  wire logic [4:0]  csr_wr_data,
   // Request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] rx_byte
   // Result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,    // [7:0] data_byte, [11:8] port,
                                          // [20:12] payload_length, [22:21] status
   output logic             rsp_tuser     // [0] kind
);
   import kfd_pkg::*;

   logic         max_ports_ff;
   logic [4:0]   ports_ff;
   logic         byte_take;
   logic         push;
   event_type    push_event;
   event_type    head_event;
   q_status_type q_status;
   logic         pop;
   result_type   result;

   // The register itself; the extra flop only records that a write has been seen.
   always_ff @(posedge clock) begin
      if (reset) begin
         ports_ff     <= 5'd0;
         max_ports_ff <= 1'b0;
      end else if (csr_wr_en) begin
         ports_ff     <= csr_wr_data;
         max_ports_ff <= 1'b1;
      end
   end

   assign req_tready = !q_status.full;
   assign byte_take  = req_tvalid && req_tready;

   // Front end: undoes escaping and turns each byte other than an escape prefix into a queue event.
   kfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_take  (byte_take),
      .rx_byte    (req_tdata),
      .push       (push),
      .push_event (push_event)
   );

   kfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .pop        (pop),
      .head_event (head_event),
      .status     (q_status)
   );

   // Back end: tracks the frame and produces results.
   kfd_back #(
      .MAX_FRAME (MAX_FRAME)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .max_ports  (ports_ff),
      .q_status   (q_status),
      .head_event (head_event),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tuser = result.kind;
   assign rsp_tdata = {1'b0, result.status, result.payload_length,
                       result.port, result.data_byte};

   // The queue is never written while it is full.
   assert property (@(posedge clock) disable iff (reset) push |-> !q_status.full)
      else $error("event queue overrun");

   // Nothing is taken from an empty queue.
   assert property (@(posedge clock) disable iff (reset) pop |-> !q_status.empty)
      else $error("event queue underrun");

   // Payload results carry no length and a good status.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_DATA) |->
         (result.payload_length == '0 && result.status == ST_GOOD))
      else $error("payload result with end-of-frame fields");

   // A result never appears without an event having been taken the cycle before.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(pop))
      else $error("result without an event");

   // Without any configuration write, every data frame is rejected.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !max_ports_ff) |-> rsp_tuser == KIND_END)
      else $error("payload emitted with no ports enabled");

endmodule
`default_nettype wire

// ===== sv/kfd_front.sv =====
`default_nettype none
module kfd_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                byte_take,
   input  wire logic [7:0]          rx_byte,
   output logic                     push,
   output kfd_pkg::event_type       push_event
);
   import kfd_pkg::*;

   logic esc_ff;
   logic esc_in;

   always_comb begin
      esc_in           = esc_ff;
      push             = 1'b0;
      push_event.is_end = 1'b0;
      push_event.value  = rx_byte;
      if (byte_take) begin
         if (rx_byte == KISS_FEND) begin
            // A boundary always ends the frame and drops any pending escape.
            push              = 1'b1;
            push_event.is_end = 1'b1;
            esc_in            = 1'b0;
         end else if (esc_ff && rx_byte == KISS_TFESC) begin
            push             = 1'b1;
            push_event.value = KISS_FESC;
            esc_in           = 1'b0;
         end else if (esc_ff && rx_byte == KISS_TFEND) begin
            push             = 1'b1;
            push_event.value = KISS_FEND;
            esc_in           = 1'b0;
         end else if (rx_byte == KISS_FESC) begin
            // Unknown escapes fall through, so a second FESC starts anew.
            esc_in = 1'b1;
         end else begin
            push   = 1'b1;
            esc_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= 1'b0;
      end else begin
         esc_ff <= esc_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/kfd_queue.sv =====
`default_nettype none
module kfd_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire kfd_pkg::event_type  push_event,
   input  wire logic                pop,
   output kfd_pkg::event_type       head_event,
   output kfd_pkg::q_status_type    status
);
   import kfd_pkg::*;

   event_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   fill_ff, fill_in;

   assign head_event   = slot_ff[rd_ptr_ff];
   assign status.full  = (fill_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_event;
      end
   end

endmodule
`default_nettype wire

// ===== sv/kfd_back.sv =====
`default_nettype none
module kfd_back #(
   parameter int MAX_FRAME = 400
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [4:0]            max_ports,
   input  wire kfd_pkg::q_status_type q_status,
   input  wire kfd_pkg::event_type    head_event,
   output logic                       pop,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output kfd_pkg::result_type        out_result
);
   import kfd_pkg::*;

   localparam int CW = $clog2(MAX_FRAME + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic          valid_ff, valid_in;
   result_type    result_ff, result_in;

   logic [3:0]    port;
   logic          accepted;
   logic [CW-1:0] len_full;

   assign port      = cmd_ff[7:4];
   assign accepted  = (cmd_ff[3:0] == 4'h0) && ({1'b0, port} < max_ports);
   assign len_full  = count_ff - CW'(1);
   assign pop       = !q_status.empty && (!valid_ff || out_ready);
   assign out_valid = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      cmd_in    = cmd_ff;
      valid_in  = valid_ff && !out_ready;
      result_in = result_ff;
      if (pop) begin
         if (head_event.is_end) begin
            if (count_ff != '0) begin
               valid_in                 = 1'b1;
               result_in.kind           = KIND_END;
               result_in.data_byte      = 8'h00;
               result_in.port           = port;
               result_in.payload_length = LEN_W'(len_full);
               if (ovf_ff) begin
                  result_in.status = ST_OVERFLOW;
               end else if (cmd_ff[3:0] != 4'h0) begin
                  result_in.status = ST_NOT_DATA;
               end else if (!accepted) begin
                  result_in.status = ST_BAD_PORT;
               end else begin
                  result_in.status = ST_GOOD;
               end
            end
            count_in = '0;
            ovf_in   = 1'b0;
         end else if (count_ff < CW'(MAX_FRAME)) begin
            if (count_ff == '0) begin
               cmd_in = head_event.value;
            end else if (accepted) begin
               valid_in                 = 1'b1;
               result_in.kind           = KIND_DATA;
               result_in.data_byte      = head_event.value;
               result_in.port           = port;
               result_in.payload_length = '0;
               result_in.status         = ST_GOOD;
            end
            count_in = count_ff + 1'b1;
         end else begin
            // Frame is full: the byte is dropped and the frame is marked.
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         cmd_ff   <= 8'h00;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         cmd_ff   <= cmd_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

endmodule
`default_nettype wire
